// ===== rtl/core/sqe_pkg.sv =====
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared types, constants and ring pointer helpers for the stack/queue engine.
// ----------------------------------------------------------------------------
package sqe_pkg;

   localparam int DEPTH    = 32;
   localparam int DATA_W   = 32;
   localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;
   localparam int SWAP_MIN = 2;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DATA_W-1:0] word_type;

   typedef enum logic [2:0] {
      ACT_PUSH  = 3'd0,
      ACT_PRINT = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_POP   = 3'd3,
      ACT_SWAP  = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      KIND_DATA       = 3'd0,
      KIND_PEEK_EMPTY = 3'd1,
      KIND_POP_EMPTY  = 3'd2,
      KIND_SWAP_SHORT = 3'd3,
      KIND_BAD_ARG    = 3'd4,
      KIND_FULL       = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PEEK,
      ST_PRINT,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SWAP_C
   } state_type;

   typedef enum logic [1:0] {
      RD_TOP,
      RD_SECOND,
      RD_WALK
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_PUSH,
      WA_TOP,
      WA_SECOND
   } wr_addr_sel_type;

   typedef enum logic [1:0] {
      WD_PUSH,
      WD_RDATA,
      WD_HOLD
   } wr_data_sel_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_DATA,
      EMIT_ERR
   } emit_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_PUSH,
      UPD_POP
   } upd_type;

   // controller to datapath
   typedef struct packed {
      logic            load;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            wr_en;
      wr_addr_sel_type wr_addr_sel;
      wr_data_sel_type wr_data_sel;
      logic            hold_load;
      logic            walk_start;
      logic            walk_step;
      upd_type         upd;
      emit_type        emit;
      kind_type        err_kind;
      logic            last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type action;
      logic       value_valid;
      logic       empty;
      logic       full;
      logic       short_for_swap;
      logic       walk_done;
   } status_type;

   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      ptr_type r;
      if (p == '0) begin
         r = ptr_type'(DEPTH - 1);
      end else begin
         r = p - ptr_type'(1);
      end
      return r;
   endfunction

   // top plus count, wrapped; the sum stays below twice the depth
   function automatic ptr_type ptr_add(input ptr_type p, input cnt_type n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + SUM_W'(n);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

endpackage

// ===== rtl/core/sqe_ram.sv =====
// ----------------------------------------------------------------------------
// sqe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sqe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sqe_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqe_ctrl
// Command sequencer: decodes the latched command against the store status and
// steps the datapath through reads, writes and result transfers.
// ----------------------------------------------------------------------------
module sqe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  sqe_pkg::status_type  status,
   output sqe_pkg::cmd_type     cmd,
   output logic                 busy
);

   sqe_pkg::state_type state_ff;
   sqe_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sqe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = sqe_pkg::RD_TOP;
      cmd.wr_addr_sel = sqe_pkg::WA_PUSH;
      cmd.wr_data_sel = sqe_pkg::WD_PUSH;
      cmd.upd         = sqe_pkg::UPD_NONE;
      cmd.emit        = sqe_pkg::EMIT_NONE;
      cmd.err_kind    = sqe_pkg::KIND_DATA;
      busy            = (state_ff != sqe_pkg::ST_IDLE);

      case (state_ff)
         sqe_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = sqe_pkg::ST_EXEC;
            end
         end

         sqe_pkg::ST_EXEC: begin
            state_in = sqe_pkg::ST_IDLE;
            case (status.action)
               sqe_pkg::ACT_PUSH: begin
                  // bad argument is checked before full
                  if (!status.value_valid) begin
                     cmd.emit     = sqe_pkg::EMIT_ERR;
                     cmd.err_kind = sqe_pkg::KIND_BAD_ARG;
                  end else if (status.full) begin
                     cmd.emit     = sqe_pkg::EMIT_ERR;
                     cmd.err_kind = sqe_pkg::KIND_FULL;
                  end else begin
                     cmd.wr_en = 1'b1;
                     cmd.upd   = sqe_pkg::UPD_PUSH;
                  end
               end
               sqe_pkg::ACT_PRINT: begin
                  if (!status.empty) begin
                     cmd.rd_en      = 1'b1;
                     cmd.walk_start = 1'b1;
                     state_in       = sqe_pkg::ST_PRINT;
                  end
               end
               sqe_pkg::ACT_PEEK: begin
                  if (status.empty) begin
                     cmd.emit     = sqe_pkg::EMIT_ERR;
                     cmd.err_kind = sqe_pkg::KIND_PEEK_EMPTY;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = sqe_pkg::ST_PEEK;
                  end
               end
               sqe_pkg::ACT_POP: begin
                  if (status.empty) begin
                     cmd.emit     = sqe_pkg::EMIT_ERR;
                     cmd.err_kind = sqe_pkg::KIND_POP_EMPTY;
                  end else begin
                     cmd.upd = sqe_pkg::UPD_POP;
                  end
               end
               sqe_pkg::ACT_SWAP: begin
                  if (status.short_for_swap) begin
                     cmd.emit     = sqe_pkg::EMIT_ERR;
                     cmd.err_kind = sqe_pkg::KIND_SWAP_SHORT;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = sqe_pkg::ST_SWAP_A;
                  end
               end
               default: begin
                  state_in = sqe_pkg::ST_IDLE;
               end
            endcase
         end

         sqe_pkg::ST_PEEK: begin
            cmd.emit = sqe_pkg::EMIT_DATA;
            cmd.last = 1'b1;
            state_in = sqe_pkg::ST_IDLE;
         end

         sqe_pkg::ST_PRINT: begin
            cmd.emit = sqe_pkg::EMIT_DATA;
            cmd.last = status.walk_done;
            if (status.walk_done) begin
               state_in = sqe_pkg::ST_IDLE;
            end else begin
               cmd.rd_en     = 1'b1;
               cmd.rd_sel    = sqe_pkg::RD_WALK;
               cmd.walk_step = 1'b1;
            end
         end

         // top word arrives, keep it and fetch the second
         sqe_pkg::ST_SWAP_A: begin
            cmd.hold_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = sqe_pkg::RD_SECOND;
            state_in      = sqe_pkg::ST_SWAP_B;
         end

         sqe_pkg::ST_SWAP_B: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = sqe_pkg::WA_TOP;
            cmd.wr_data_sel = sqe_pkg::WD_RDATA;
            state_in        = sqe_pkg::ST_SWAP_C;
         end

         sqe_pkg::ST_SWAP_C: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = sqe_pkg::WA_SECOND;
            cmd.wr_data_sel = sqe_pkg::WD_HOLD;
            state_in        = sqe_pkg::ST_IDLE;
         end

         default: begin
            state_in = sqe_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/sqe_dp.sv =====
// ----------------------------------------------------------------------------
// sqe_dp
// Datapath: ring buffer storage, top pointer and fill count, mode register,
// print walk pointer and the registered result port.
// ----------------------------------------------------------------------------
module sqe_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  sqe_pkg::cmd_type           cmd,
   output sqe_pkg::status_type        status,
   input  logic [2:0]                 req_action,
   input  logic signed [31:0]         req_push_value,
   input  logic                       req_value_valid,
   input  logic                       csr_write_enable,
   input  logic                       csr_write_data,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_kind,
   output logic signed [31:0]         rsp_data,
   output logic                       rsp_last
);

   logic                  queue_mode_ff;
   sqe_pkg::ptr_type      top_ff;
   sqe_pkg::ptr_type      top_in;
   sqe_pkg::cnt_type      fill_ff;
   sqe_pkg::cnt_type      fill_in;
   sqe_pkg::action_type   action_ff;
   sqe_pkg::word_type     value_ff;
   logic                  valid_ff;
   sqe_pkg::ptr_type      walk_ptr_ff;
   sqe_pkg::cnt_type      walk_cnt_ff;
   sqe_pkg::word_type     hold_ff;
   logic                  rsp_valid_ff;
   sqe_pkg::kind_type     rsp_kind_ff;
   sqe_pkg::word_type     rsp_data_ff;
   logic                  rsp_last_ff;

   sqe_pkg::ptr_type      second_ptr;
   sqe_pkg::ptr_type      push_ptr;
   sqe_pkg::ptr_type      rd_addr;
   sqe_pkg::ptr_type      wr_addr;
   sqe_pkg::word_type     wr_data;
   sqe_pkg::word_type     rd_data;

   assign second_ptr = sqe_pkg::ptr_inc(top_ff);
   // queue appends below the last entry, stack grows above the top
   assign push_ptr   = queue_mode_ff ? sqe_pkg::ptr_add(top_ff, fill_ff)
                                     : sqe_pkg::ptr_dec(top_ff);

   always_comb begin
      case (cmd.rd_sel)
         sqe_pkg::RD_TOP:    rd_addr = top_ff;
         sqe_pkg::RD_SECOND: rd_addr = second_ptr;
         sqe_pkg::RD_WALK:   rd_addr = walk_ptr_ff;
         default:            rd_addr = top_ff;
      endcase
      case (cmd.wr_addr_sel)
         sqe_pkg::WA_PUSH:   wr_addr = push_ptr;
         sqe_pkg::WA_TOP:    wr_addr = top_ff;
         sqe_pkg::WA_SECOND: wr_addr = second_ptr;
         default:            wr_addr = push_ptr;
      endcase
      case (cmd.wr_data_sel)
         sqe_pkg::WD_PUSH:  wr_data = value_ff;
         sqe_pkg::WD_RDATA: wr_data = rd_data;
         sqe_pkg::WD_HOLD:  wr_data = hold_ff;
         default:           wr_data = value_ff;
      endcase
   end

   sqe_ram #(
      .WIDTH (sqe_pkg::DATA_W),
      .DEPTH (sqe_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      top_in  = top_ff;
      fill_in = fill_ff;
      case (cmd.upd)
         sqe_pkg::UPD_PUSH: begin
            fill_in = fill_ff + sqe_pkg::cnt_type'(1);
            if (!queue_mode_ff) begin
               top_in = push_ptr;
            end
         end
         sqe_pkg::UPD_POP: begin
            fill_in = fill_ff - sqe_pkg::cnt_type'(1);
            top_in  = second_ptr;
         end
         default: begin
            top_in  = top_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_mode_ff <= 1'b0;
         top_ff        <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            queue_mode_ff <= csr_write_data;
         end
         top_ff       <= top_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= (cmd.emit != sqe_pkg::EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= sqe_pkg::action_type'(req_action);
         value_ff  <= sqe_pkg::word_type'(req_push_value);
         valid_ff  <= req_value_valid;
      end
      if (cmd.hold_load) begin
         hold_ff <= rd_data;
      end
      // walk count tracks entries already fetched
      if (cmd.walk_start) begin
         walk_ptr_ff <= second_ptr;
         walk_cnt_ff <= sqe_pkg::cnt_type'(1);
      end else if (cmd.walk_step) begin
         walk_ptr_ff <= sqe_pkg::ptr_inc(walk_ptr_ff);
         walk_cnt_ff <= walk_cnt_ff + sqe_pkg::cnt_type'(1);
      end
      case (cmd.emit)
         sqe_pkg::EMIT_DATA: begin
            rsp_kind_ff <= sqe_pkg::KIND_DATA;
            rsp_data_ff <= rd_data;
            rsp_last_ff <= cmd.last;
         end
         sqe_pkg::EMIT_ERR: begin
            rsp_kind_ff <= cmd.err_kind;
            rsp_data_ff <= '0;
            rsp_last_ff <= 1'b1;
         end
         default: begin
            rsp_kind_ff <= rsp_kind_ff;
         end
      endcase
   end

   assign status.action         = action_ff;
   assign status.value_valid    = valid_ff;
   assign status.empty          = (fill_ff == '0);
   assign status.full           = (fill_ff == sqe_pkg::cnt_type'(sqe_pkg::DEPTH));
   assign status.short_for_swap = (fill_ff < sqe_pkg::cnt_type'(sqe_pkg::SWAP_MIN));
   assign status.walk_done      = (walk_cnt_ff == fill_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== rtl/core/stack_queue_engine.sv =====
// ----------------------------------------------------------------------------
// stack_queue_engine
// Bounded store of signed 32-bit words used as a stack or a queue, with push,
// print-all, peek, pop and swap commands and error results.
// ----------------------------------------------------------------------------
//   channel   ports                                   transfer
//   request   start, busy, req_action,                start high, busy low
//             req_push_value, req_value_valid
//   response  rsp_valid, rsp_kind, rsp_data, rsp_last rsp_valid high
//   config    csr_write_enable, csr_write_data        csr_write_enable high
//
// a command is taken in one cycle and decoded in the next: push, pop and any
// error finish in the decode state; peek, swap and print-all go on through
// further states, since the ring buffer RAM has one registered read port.
// results are registered, leave the cycle after they are formed and the
// receiver cannot stall them. after reset the store is empty and stack
// mode is set.
// ----------------------------------------------------------------------------
module stack_queue_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_push_value,
   input  logic               req_value_valid,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   output logic               rsp_valid,
   output logic [2:0]         rsp_kind,
   output logic signed [31:0] rsp_data,
   output logic               rsp_last
);

   sqe_pkg::cmd_type    cmd;
   sqe_pkg::status_type status;

   sqe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sqe_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_push_value   (req_push_value),
      .req_value_valid  (req_value_valid),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_last         (rsp_last)
   );

endmodule
